// ----- sv/json_string_unescape_utf8_core_defines.svh -----
// ---------------------------------------------------------------------------
// JSON string unescape core - assertion macros
// Assertion helpers clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JSU_ASSERT_IMP(lbl, ante, cons, msg)
`define JSU_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/jsu_pkg.sv -----
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the JSON string unescape core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ESCEND  = 3'd1;
    localparam logic [2:0] ST_BADHEX  = 3'd2;
    localparam logic [2:0] ST_BADSUR  = 3'd3;
    localparam logic [2:0] ST_BADESC  = 3'd4;
    localparam logic [2:0] ST_CTRL    = 3'd5;
    localparam logic [2:0] ST_NOQUOTE = 3'd6;

    // One decoded input item: a status, or one to four data bytes
    typedef struct packed {
        logic            is_status;
        logic [2:0]      status;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } job_t;

endpackage

// ----- sv/json_string_unescape_utf8_core.sv -----
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Decodes JSON string bodies byte by byte into UTF-8 bytes and a status item.
// ---------------------------------------------------------------------------
// Takes one body byte per cycle while the job queue is not full. Each input
// item is decoded in the front state machine in the cycle it is accepted
// and becomes at most one job of one to four result items; jobs wait in a
// four-entry queue and the serializer hands out one result item per cycle
// while m_tready is high. Plain bytes and simple escapes yield one item; a
// completed \u escape yields one to four, and s_tready drops only while the
// job queue is full. Raise s_tuser with the first byte of each new string.
`timescale 1ns / 1ps

module json_string_unescape_utf8_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    input  logic [0:0]   s_tuser,   // [0] restart
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
    output logic [0:0]   m_tuser,   // [0] kind
    output logic         m_tlast
);

    jsu_pkg::job_t push_job;
    jsu_pkg::job_t head;
    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    logic          accept;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    jsu_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .restart (s_tuser[0]),
        .push    (push),
        .job     (push_job)
    );

    jsu_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    jsu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- sv/jsu_front.sv -----
// ---------------------------------------------------------------------------
// jsu_front
// Decoder state machine: one body byte per cycle on accept, at most one job each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             restart,
    output logic             push,
    output jsu_pkg::job_t    job
);

    typedef enum logic [2:0] {M_NORMAL, M_ESC, M_HEX1, M_BS, M_U, M_HEX2} mode_t;

    mode_t       mode_reg,  mode_next;
    logic [1:0]  hcnt_reg,  hcnt_next;
    logic [15:0] acc_reg,   acc_next;
    logic [9:0]  high_reg,  high_next;
    logic        fin_reg,   fin_next;

    mode_t       eff_mode;
    logic [1:0]  eff_cnt;
    logic [15:0] eff_acc;
    logic [9:0]  eff_high;
    logic        eff_fin;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] acc_shift;
    logic [20:0] pair_cp;

    function automatic jsu_pkg::job_t mk_data(input logic [7:0] b);
        jsu_pkg::job_t j;
        j          = '0;
        j.bytes[0] = b;
        return j;
    endfunction

    function automatic jsu_pkg::job_t mk_status(input logic [2:0] s);
        jsu_pkg::job_t j;
        j           = '0;
        j.is_status = jsu_pkg::KIND_STATUS;
        j.status    = s;
        return j;
    endfunction

    function automatic jsu_pkg::job_t utf8(input logic [20:0] cp);
        jsu_pkg::job_t j;
        j = '0;
        if (cp <= 21'h7F)
        begin
            j.bytes[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF)
        begin
            j.last_idx = 2'd1;
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF)
        begin
            j.last_idx = 2'd2;
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            j.last_idx = 2'd3;
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
        end
        return j;
    endfunction

    // Restart clears the state before the byte is taken
    always_comb
    begin
        eff_mode = restart ? M_NORMAL : mode_reg;
        eff_cnt  = restart ? 2'd0     : hcnt_reg;
        eff_acc  = restart ? 16'd0    : acc_reg;
        eff_high = restart ? 10'd0    : high_reg;
        eff_fin  = restart ? 1'b0     : fin_reg;
    end

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte inside {[8'h30:8'h39]})
            hex_val = in_byte[3:0];
        else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]})
            hex_val = in_byte[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    assign acc_shift = {eff_acc[11:0], hex_val};
    assign pair_cp   = 21'h10000 + {1'b0, eff_high, acc_shift[9:0]};

    always_comb
    begin
        mode_next = eff_mode;
        hcnt_next = eff_cnt;
        acc_next  = eff_acc;
        high_next = eff_high;
        fin_next  = eff_fin;
        push      = 1'b0;
        job       = '0;
        if (!eff_fin)
        begin
            case (eff_mode)
                M_ESC:
                begin
                    mode_next = M_NORMAL;
                    push      = 1'b1;
                    case (in_byte)
                        8'h00: begin job = mk_status(jsu_pkg::ST_ESCEND); fin_next = 1'b1; end
                        "n":   job = mk_data(8'h0A);
                        "b":   job = mk_data(8'h08);
                        "f":   job = mk_data(8'h0C);
                        "r":   job = mk_data(8'h0D);
                        "t":   job = mk_data(8'h09);
                        "/":   job = mk_data(8'h2F);
                        "\"":  job = mk_data(8'h22);
                        "\\":  job = mk_data(8'h5C);
                        "u":
                        begin
                            push      = 1'b0;
                            mode_next = M_HEX1;
                            hcnt_next = 2'd0;
                            acc_next  = 16'd0;
                        end
                        default: begin job = mk_status(jsu_pkg::ST_BADESC); fin_next = 1'b1; end
                    endcase
                end
                M_HEX1, M_HEX2:
                begin
                    if (!hex_ok)
                    begin
                        push      = 1'b1;
                        job       = mk_status(jsu_pkg::ST_BADHEX);
                        fin_next  = 1'b1;
                        mode_next = M_NORMAL;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        if (eff_cnt != 2'd3)
                        begin
                            hcnt_next = eff_cnt + 2'd1;
                        end
                        else
                        begin
                            hcnt_next = 2'd0;
                            push      = 1'b1;
                            mode_next = M_NORMAL;
                            if (eff_mode == M_HEX1)
                            begin
                                if (acc_shift inside {[16'hD800:16'hDBFF]})
                                begin
                                    push      = 1'b0;
                                    high_next = acc_shift[9:0];
                                    mode_next = M_BS;
                                end
                                else
                                begin
                                    job = utf8({5'd0, acc_shift});
                                end
                            end
                            else if (acc_shift inside {[16'hDC00:16'hDFFF]})
                            begin
                                job = utf8(pair_cp);
                            end
                            else
                            begin
                                job      = mk_status(jsu_pkg::ST_BADSUR);
                                fin_next = 1'b1;
                            end
                        end
                    end
                end
                M_BS:
                begin
                    if (in_byte == "\\")
                    begin
                        mode_next = M_U;
                    end
                    else
                    begin
                        push      = 1'b1;
                        job       = mk_status(jsu_pkg::ST_BADSUR);
                        fin_next  = 1'b1;
                        mode_next = M_NORMAL;
                    end
                end
                M_U:
                begin
                    if (in_byte == "u")
                    begin
                        mode_next = M_HEX2;
                        hcnt_next = 2'd0;
                        acc_next  = 16'd0;
                    end
                    else
                    begin
                        push      = 1'b1;
                        job       = mk_status(jsu_pkg::ST_BADSUR);
                        fin_next  = 1'b1;
                        mode_next = M_NORMAL;
                    end
                end
                default:
                begin
                    mode_next = M_NORMAL;
                    push      = 1'b1;
                    if (in_byte == 8'h00)
                    begin
                        job      = mk_status(jsu_pkg::ST_NOQUOTE);
                        fin_next = 1'b1;
                    end
                    else if (in_byte == "\"")
                    begin
                        job      = mk_status(jsu_pkg::ST_OK);
                        fin_next = 1'b1;
                    end
                    else if (in_byte == "\\")
                    begin
                        push      = 1'b0;
                        mode_next = M_ESC;
                    end
                    else if (in_byte < 8'h20)
                    begin
                        job      = mk_status(jsu_pkg::ST_CTRL);
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        job = mk_data(in_byte);
                    end
                end
            endcase
        end
        if (!accept)
            push = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_NORMAL;
            hcnt_reg <= 2'd0;
            acc_reg  <= 16'd0;
            high_reg <= 10'd0;
            fin_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hcnt_reg <= hcnt_next;
            acc_reg  <= acc_next;
            high_reg <= high_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

// ----- sv/jsu_queue.sv -----
// ---------------------------------------------------------------------------
// jsu_queue
// Short job queue between the decoder and the byte serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_core_defines.svh"

module jsu_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jsu_pkg::job_t    push_job,
    output logic             full,
    input  logic             pop,
    output jsu_pkg::job_t    head,
    output logic             empty
);

    jsu_pkg::job_t                    mem_reg [jsu_pkg::QDEPTH];
    logic [jsu_pkg::QPTR_W-1:0]       wptr_reg, wptr_next;
    logic [jsu_pkg::QPTR_W-1:0]       rptr_reg, rptr_next;
    logic [jsu_pkg::QCNT_W-1:0]       cnt_reg,  cnt_next;

    assign full  = (cnt_reg == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + jsu_pkg::QPTR_W'(1) : wptr_reg;
        rptr_next = pop  ? rptr_reg + jsu_pkg::QPTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + jsu_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - jsu_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    `JSU_ASSERT_IMP(a_no_push_full, push, !full, "job pushed into full queue")
    `JSU_ASSERT_IMP(a_no_pop_empty, pop, !empty, "job popped from empty queue")
    `JSU_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH),
                    "queue count beyond depth")

endmodule

// ----- sv/jsu_back.sv -----
// ---------------------------------------------------------------------------
// jsu_back
// Serializer: walks the head job one byte per cycle, unless stalled, into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_core_defines.svh"

module jsu_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  jsu_pkg::job_t    head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic [0:0]       m_tuser,
    output logic             m_tlast
);

    logic [1:0] idx_reg,   idx_next;
    logic       ovld_reg,  ovld_next;
    logic       kind_reg,  kind_next;
    logic [7:0] byte_reg,  byte_next;
    logic [2:0] stat_reg,  stat_next;
    logic       last_reg,  last_next;
    logic       load;
    logic       at_end;

    assign load   = !empty && (!ovld_reg || m_tready);
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next  = idx_reg;
        ovld_next = ovld_reg && !m_tready;
        kind_next = kind_reg;
        byte_next = byte_reg;
        stat_next = stat_reg;
        last_next = last_reg;
        if (load)
        begin
            ovld_next = 1'b1;
            kind_next = head.is_status;
            byte_next = head.is_status ? 8'd0 : head.bytes[idx_reg];
            stat_next = head.status;
            last_next = at_end;
            idx_next  = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        stat_reg <= stat_next;
        last_reg <= last_next;
    end

    assign m_tvalid   = ovld_reg;
    assign m_tdata    = {5'd0, stat_reg, byte_reg};
    assign m_tuser[0] = kind_reg;
    assign m_tlast    = last_reg;

    `JSU_ASSERT_NXT(a_pop_shows_last, pop, ovld_reg && last_reg,
                    "job retired without its final item in the output register")

endmodule

// ----- tb/json_string_unescape_utf8_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_core_tb
// Streams JSON string bodies into the unescape core and checks every decoded
// byte and status item against a cycle-free decoder kept in the bench.
// ---------------------------------------------------------------------------

module json_string_unescape_utf8_core_tb;

    localparam int          RUN_LIMIT  = 400000;
    localparam logic [7:0]  CH_QUOTE   = 8'h22;
    localparam logic [7:0]  CH_BSLASH  = 8'h5C;
    localparam logic [7:0]  CH_U       = 8'h75;

    typedef enum logic [2:0] {
        MODE_BODY,
        MODE_ESC,
        MODE_HEX_FIRST,
        MODE_PAIR_BS,
        MODE_PAIR_U,
        MODE_HEX_SECOND
    } dec_mode_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [2:0] status;
        logic       last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
    logic [0:0]  s_tuser = 1'b0;    // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] out_byte, [10:8] status, [15:11] zero
    logic [0:0]  m_tuser;           // [0] kind
    logic        m_tlast;

    // decoder state mirrored in the bench
    dec_mode_t   dec_mode = MODE_BODY;
    logic [1:0]  dec_hex_cnt = 2'd0;
    logic [15:0] dec_code = 16'd0;
    logic [9:0]  dec_high = 10'd0;
    logic        dec_done = 1'b0;

    result_t     step_res [0:3];
    int          step_n;
    result_t     decoded_q [$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          active_items = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    logic        fresh = 1'b0;

    json_string_unescape_utf8_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic bit is_escape_char(input logic [7:0] c);
        return c == 8'h00 || c == CH_QUOTE || c == CH_BSLASH || c == "/" || c == "b" ||
               c == "f" || c == "n" || c == "r" || c == "t" || c == CH_U;
    endfunction

    function automatic void emit_data(input logic [7:0] val);
        step_res[step_n] = '{kind: jsu_pkg::KIND_DATA, data: val, status: jsu_pkg::ST_OK,
                             last: 1'b0};
        step_n++;
    endfunction

    function automatic void give_status(input logic [2:0] st);
        step_res[step_n] = '{kind: jsu_pkg::KIND_STATUS, data: 8'h00, status: st,
                             last: 1'b0};
        step_n++;
        dec_done = 1'b1;
        dec_mode = MODE_BODY;
    endfunction

    function automatic void emit_utf8(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            emit_data(cp[7:0]);
        end
        else if (cp <= 21'h7FF) begin
            emit_data({3'b110, cp[10:6]});
            emit_data({2'b10, cp[5:0]});
        end
        else if (cp <= 21'hFFFF) begin
            emit_data({4'b1110, cp[15:12]});
            emit_data({2'b10, cp[11:6]});
            emit_data({2'b10, cp[5:0]});
        end
        else begin
            emit_data({5'b11110, cp[20:18]});
            emit_data({2'b10, cp[17:12]});
            emit_data({2'b10, cp[11:6]});
            emit_data({2'b10, cp[5:0]});
        end
    endfunction

    // Returns 0 when the item is ignored after a status.
    function automatic bit decode_item(input logic [7:0] c, input logic rs);
        int      h;
        result_t r;
        if (rs) begin
            dec_mode    = MODE_BODY;
            dec_hex_cnt = 2'd0;
            dec_code    = 16'd0;
            dec_high    = 10'd0;
            dec_done    = 1'b0;
        end
        step_n = 0;
        if (dec_done) return 1'b0;
        case (dec_mode)
            MODE_ESC:
            begin
                dec_mode = MODE_BODY;
                case (c)
                    8'h00:     give_status(jsu_pkg::ST_ESCEND);
                    "n":       emit_data(8'h0A);
                    "b":       emit_data(8'h08);
                    "f":       emit_data(8'h0C);
                    "r":       emit_data(8'h0D);
                    "t":       emit_data(8'h09);
                    "/":       emit_data(c);
                    CH_QUOTE:  emit_data(c);
                    CH_BSLASH: emit_data(c);
                    CH_U:
                    begin
                        dec_mode    = MODE_HEX_FIRST;
                        dec_hex_cnt = 2'd0;
                        dec_code    = 16'd0;
                    end
                    default:   give_status(jsu_pkg::ST_BADESC);
                endcase
            end
            MODE_HEX_FIRST, MODE_HEX_SECOND:
            begin
                h = hex_value(c);
                if (h < 0) begin
                    give_status(jsu_pkg::ST_BADHEX);
                end
                else begin
                    dec_code = {dec_code[11:0], h[3:0]};
                    if (dec_hex_cnt != 2'd3) begin
                        dec_hex_cnt++;
                    end
                    else begin
                        dec_hex_cnt = 2'd0;
                        if (dec_mode == MODE_HEX_FIRST) begin
                            if (dec_code >= 16'hD800 && dec_code <= 16'hDBFF) begin
                                dec_high = dec_code[9:0];
                                dec_mode = MODE_PAIR_BS;
                            end
                            else begin
                                dec_mode = MODE_BODY;
                                emit_utf8({5'd0, dec_code});
                            end
                        end
                        else if (dec_code < 16'hDC00 || dec_code > 16'hDFFF) begin
                            give_status(jsu_pkg::ST_BADSUR);
                        end
                        else begin
                            dec_mode = MODE_BODY;
                            emit_utf8(21'h10000 + {1'b0, dec_high, dec_code[9:0]});
                        end
                    end
                end
            end
            MODE_PAIR_BS:
            begin
                if (c == CH_BSLASH) dec_mode = MODE_PAIR_U;
                else give_status(jsu_pkg::ST_BADSUR);
            end
            MODE_PAIR_U:
            begin
                if (c == CH_U) begin
                    dec_mode    = MODE_HEX_SECOND;
                    dec_hex_cnt = 2'd0;
                    dec_code    = 16'd0;
                end
                else begin
                    give_status(jsu_pkg::ST_BADSUR);
                end
            end
            default:
            begin
                dec_mode = MODE_BODY;
                if (c == 8'h00) give_status(jsu_pkg::ST_NOQUOTE);
                else if (c == CH_QUOTE) give_status(jsu_pkg::ST_OK);
                else if (c == CH_BSLASH) dec_mode = MODE_ESC;
                else if (c < 8'h20) give_status(jsu_pkg::ST_CTRL);
                else emit_data(c);
            end
        endcase
        for (int i = 0; i < step_n; i++) begin
            r = step_res[i];
            r.last = (i == step_n - 1);
            decoded_q.push_back(r);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] val, input logic rs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= rs;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (decode_item(val, rs)) active_items++;
    endtask

    // first byte after a string start carries the restart flag
    task automatic put_byte(input logic [7:0] val);
        send_item(val, fresh);
        fresh = 1'b0;
    endtask

    task automatic send_hex(input logic [15:0] code);
        logic [3:0] nib;
        for (int i = 3; i >= 0; i--) begin
            nib = code[i*4 +: 4];
            if (nib < 4'd10) put_byte("0" + nib);
            else if ($urandom_range(1)) put_byte("a" + nib - 4'd10);
            else put_byte("A" + nib - 4'd10);
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%s", msg);
    endtask

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                note_mismatch($sformatf(
                    "unexpected item: kind %0d byte %02h status %0d last %0d",
                    m_tuser[0], m_tdata[7:0], m_tdata[10:8], m_tlast));
            end
            else begin
                want = decoded_q.pop_front();
                if (want.kind !== m_tuser[0] || want.data !== m_tdata[7:0] ||
                    want.status !== m_tdata[10:8] || want.last !== m_tlast)
                    note_mismatch($sformatf({
                        "mismatch: expected kind %0d byte %02h status %0d last %0d, ",
                        "got kind %0d byte %02h status %0d last %0d"},
                        want.kind, want.data, want.status, want.last,
                        m_tuser[0], m_tdata[7:0], m_tdata[10:8], m_tlast));
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_control_and_passthrough();
        send_item(8'h20, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h1F, 1'b0);
        // ignored: status already given
        send_item("x", 1'b0);
        send_item(8'h01, 1'b1);
    endtask

    task automatic test_escape_errors();
        send_item(CH_BSLASH, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(CH_BSLASH, 1'b1);
        send_item("q", 1'b0);
        send_item(CH_BSLASH, 1'b1);
        send_item(CH_U, 1'b0);
        send_item("g", 1'b0);
        send_item(CH_BSLASH, 1'b1);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
    endtask

    task automatic test_unicode_edges();
        // lone low surrogate, then end of text without a quote
        fresh = 1'b1;
        put_byte(CH_BSLASH);
        put_byte(CH_U);
        send_hex(16'hDFFF);
        put_byte(8'h00);
        // escaped zero is data, not end of text
        fresh = 1'b1;
        put_byte(CH_BSLASH);
        put_byte(CH_U);
        send_hex(16'h0000);
        put_byte(CH_QUOTE);
    endtask

    task automatic send_random_string();
        logic [7:0]  b;
        logic [15:0] code;
        int          count;
        int          pick;
        fresh = 1'b1;
        if ($urandom_range(9) == 0) begin
            // noise: raw bytes with occasional restarts
            count = $urandom_range(6, 1);
            for (int i = 0; i < count; i++) begin
                b = $urandom_range(255);
                send_item(b, fresh || ($urandom_range(3) == 0));
                fresh = 1'b0;
            end
            return;
        end
        count = $urandom_range(6);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 55 && pick >= 35) begin
                put_byte(CH_BSLASH);
                case ($urandom_range(7))
                    0: put_byte(CH_QUOTE);
                    1: put_byte(CH_BSLASH);
                    2: put_byte("/");
                    3: put_byte("b");
                    4: put_byte("f");
                    5: put_byte("n");
                    6: put_byte("r");
                    default: put_byte("t");
                endcase
            end
            else if (pick >= 55 && pick < 90) begin
                put_byte(CH_BSLASH);
                put_byte(CH_U);
                case ($urandom_range(5))
                    0: send_hex($urandom_range(16'h7F));
                    1: send_hex($urandom_range(16'h7FF, 16'h80));
                    2:
                    begin
                        do code = $urandom_range(16'hFFFF, 16'h800);
                        while (code >= 16'hD800 && code <= 16'hDFFF);
                        send_hex(code);
                    end
                    3: send_hex($urandom_range(16'hDFFF, 16'hDC00));
                    default:
                    begin
                        send_hex($urandom_range(16'hDBFF, 16'hD800));
                        put_byte(CH_BSLASH);
                        put_byte(CH_U);
                        send_hex($urandom_range(16'hDFFF, 16'hDC00));
                    end
                endcase
            end
            else begin
                if ($urandom_range(3) == 0) b = $urandom_range(255, 128);
                else do b = $urandom_range(8'h7F, 8'h20);
                     while (b == CH_QUOTE || b == CH_BSLASH);
                put_byte(b);
            end
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            put_byte(CH_QUOTE);
        end
        else if (pick < 75) begin
            put_byte(8'h00);
        end
        else begin
            case ($urandom_range(5))
                0: put_byte($urandom_range(8'h1F, 8'h01));
                1:
                begin
                    put_byte(CH_BSLASH);
                    put_byte(8'h00);
                end
                2:
                begin
                    put_byte(CH_BSLASH);
                    do b = $urandom_range(255);
                    while (is_escape_char(b));
                    put_byte(b);
                end
                3:
                begin
                    put_byte(CH_BSLASH);
                    put_byte(CH_U);
                    count = $urandom_range(3);
                    for (int i = 0; i < count; i++) put_byte("0" + $urandom_range(9));
                    do b = $urandom_range(255);
                    while (hex_value(b) >= 0);
                    put_byte(b);
                end
                default:
                begin
                    // broken surrogate pair
                    put_byte(CH_BSLASH);
                    put_byte(CH_U);
                    send_hex($urandom_range(16'hDBFF, 16'hD800));
                    case ($urandom_range(2))
                        0:
                        begin
                            do b = $urandom_range(255);
                            while (b == CH_BSLASH);
                            put_byte(b);
                        end
                        1:
                        begin
                            put_byte(CH_BSLASH);
                            do b = $urandom_range(255);
                            while (b == CH_U);
                            put_byte(b);
                        end
                        default:
                        begin
                            put_byte(CH_BSLASH);
                            put_byte(CH_U);
                            do code = $urandom_range(16'hFFFF);
                            while (code >= 16'hDC00 && code <= 16'hDFFF);
                            send_hex(code);
                        end
                    endcase
                end
            endcase
        end
        // trailing bytes without restart are dropped by the block
        if ($urandom_range(3) == 0) begin
            count = $urandom_range(2, 1);
            for (int i = 0; i < count; i++) put_byte($urandom_range(255));
        end
    endtask

    task automatic test_random_strings(input int target, input int send_pct,
                                       input int recv_pct);
        int start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = active_items;
        while (active_items - start < target) send_random_string();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 11;
        recv_idle_pct = 68;
        test_control_and_passthrough();
        test_escape_errors();
        test_unicode_edges();
        test_random_strings(72, 11, 68);
        test_random_strings(72, 68, 11);
        test_random_strings(72, 0, 0);
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
